>>> rtl/ec_affine_point_add_double_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine point adder
// Concurrent checks used by the controller module.
// ----------------------------------------------------------------------------
`ifndef EC_AFFINE_POINT_ADD_DOUBLE_DEFINES_SVH
`define EC_AFFINE_POINT_ADD_DOUBLE_DEFINES_SVH

// implication check under the async reset
`define EC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check under the async reset
`define EC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Command and status types shared by the point adder controller and datapath.
// ----------------------------------------------------------------------------
package ecpa_pkg;

	// datapath operations
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;  // reduce inputs, latch operands
	localparam logic [3:0] OP_PREP  = 4'd2;  // form numerator/denominator inputs
	localparam logic [3:0] OP_MUL   = 4'd3;  // start modular multiply
	localparam logic [3:0] OP_DEN   = 4'd4;  // finish num/den
	localparam logic [3:0] OP_INV   = 4'd5;  // start inverse
	localparam logic [3:0] OP_SLOPE = 4'd6;  // latch slope from product
	localparam logic [3:0] OP_X3    = 4'd7;  // x3 from s^2
	localparam logic [3:0] OP_Y3    = 4'd8;  // y3 from product
	localparam logic [3:0] OP_INF   = 4'd9;  // force infinity

	// multiplier operand selection
	localparam logic [2:0] MSEL_X1X1 = 3'd0;
	localparam logic [2:0] MSEL_NINV = 3'd1;
	localparam logic [2:0] MSEL_SS   = 3'd2;
	localparam logic [2:0] MSEL_SDX  = 3'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] msel;
	} ecpa_cmd_t;

	typedef struct packed {
		logic red_done;   // input reduction complete
		logic mul_done;
		logic inv_done;
		logic inv_fail;   // no inverse
		logic den_zero;
		logic mod_small;  // modulus below two
	} ecpa_sts_t;

endpackage

>>> rtl/ecpa_datapath.sv
// ----------------------------------------------------------------------------
// ecpa_datapath
// Field arithmetic: serial reduction, bit-serial multiply, Euclid inverse.
// ----------------------------------------------------------------------------
module ecpa_datapath import ecpa_pkg::*; #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ecpa_cmd_t    cmd,
	output ecpa_sts_t    sts,
	input  logic [W-1:0] prime_modulus,
	input  logic [W-1:0] curve_coeff_a,
	input  logic [W-1:0] first_x,
	input  logic [W-1:0] first_y,
	input  logic [W-1:0] second_x,
	input  logic [W-1:0] second_y,
	output logic [W-1:0] res_x,
	output logic [W-1:0] res_y,
	output logic         res_inf
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] m;
	assign m = prime_modulus;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] mm);
		logic [W:0] s;
		begin
			s = {1'b0, x} + {1'b0, y};
			addm = (s >= {1'b0, mm}) ? W'(s - {1'b0, mm}) : s[W-1:0];
		end
	endfunction

	function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] mm);
		begin
			subm = (x >= y) ? (x - y) : (mm - (y - x));
		end
	endfunction

	// operand registers
	logic [W-1:0] x1_q, y1_q, x2_q, y2_q, a_q, num_q, den_q, s_q, x3_q;
	logic [W-1:0] rx_q, ry_q;
	logic         rinf_q;

	// reduction unit: restoring shift-subtract, one value at a time
	logic [2:0]   red_idx_q;
	logic [CW:0]  red_cnt_q;
	logic [W-1:0] red_rem_q;
	logic [W-1:0] red_src_q;
	logic [W-1:0] raw_y1_q, raw_x2_q, raw_y2_q;
	logic         red_busy_q, red_done_q;
	logic [W:0]   red_trial;
	logic [W:0]   red_next;
	logic         red_last;

	assign red_trial = {red_rem_q, red_src_q[W-1]};
	assign red_next  = (red_trial >= {1'b0, m}) ? (red_trial - {1'b0, m}) : red_trial;
	assign red_last  = (red_cnt_q == (CW+1)'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_busy_q <= 1'b0;
			red_done_q <= 1'b0;
			red_idx_q  <= '0;
			red_cnt_q  <= '0;
		end else begin
			red_done_q <= red_busy_q && red_last && (red_idx_q == 3'd4);
			if (cmd.op == OP_LOAD && !red_busy_q) begin
				// capture the whole transaction, first value goes straight in
				red_busy_q <= 1'b1;
				red_idx_q  <= 3'd0;
				red_cnt_q  <= '0;
				red_rem_q  <= '0;
				red_src_q  <= first_x;
				raw_y1_q   <= first_y;
				raw_x2_q   <= second_x;
				raw_y2_q   <= second_y;
			end else if (red_busy_q) begin
				if (red_last) begin
					red_cnt_q <= '0;
					red_rem_q <= '0;
					case (red_idx_q)
						3'd0: x1_q <= red_next[W-1:0];
						3'd1: y1_q <= red_next[W-1:0];
						3'd2: x2_q <= red_next[W-1:0];
						3'd3: y2_q <= red_next[W-1:0];
						default: a_q <= red_next[W-1:0];
					endcase
					if (red_idx_q == 3'd4) begin
						red_busy_q <= 1'b0;
					end else begin
						red_idx_q <= red_idx_q + 3'd1;
						case (red_idx_q)
							3'd0: red_src_q <= raw_y1_q;
							3'd1: red_src_q <= raw_x2_q;
							3'd2: red_src_q <= raw_y2_q;
							default: red_src_q <= curve_coeff_a;
						endcase
					end
				end else begin
					red_cnt_q <= red_cnt_q + (CW+1)'(1);
					red_src_q <= {red_src_q[W-2:0], 1'b0};
					red_rem_q <= red_next[W-1:0];
				end
			end
		end
	end

	// bit-serial modular multiplier, MSB first
	logic [W-1:0] mop_a, mop_b, mb_q, ma_q, acc_q, prod_q;
	logic [CW:0]  mcnt_q;
	logic         mbusy_q, mdone_q;
	logic [W-1:0] acc2, acc3;
	logic [W-1:0] inv_q;

	always_comb begin
		case (cmd.msel)
			MSEL_X1X1: begin mop_a = x1_q; mop_b = x1_q; end
			MSEL_NINV: begin mop_a = num_q; mop_b = inv_q; end
			MSEL_SS:   begin mop_a = s_q; mop_b = s_q; end
			MSEL_SDX:  begin mop_a = s_q; mop_b = subm(x1_q, x3_q, m); end
			default:   begin mop_a = '0; mop_b = '0; end
		endcase
	end

	assign acc2 = addm(acc_q, acc_q, m);
	assign acc3 = mb_q[W-1] ? addm(acc2, ma_q, m) : acc2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= mbusy_q && (mcnt_q == (CW+1)'(W - 1));
			if (cmd.op == OP_MUL && !mbusy_q) begin
				mbusy_q <= 1'b1;
				ma_q    <= mop_a;
				mb_q    <= mop_b;
				acc_q   <= '0;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				acc_q <= acc3;
				mb_q  <= {mb_q[W-2:0], 1'b0};
				if (mcnt_q == (CW+1)'(W - 1)) begin
					mbusy_q <= 1'b0;
					prod_q  <= acc3;
				end else begin
					mcnt_q <= mcnt_q + (CW+1)'(1);
				end
			end
		end
	end

	// extended Euclid: one restoring division per step, with
	// q*t1 mod m accumulated MSB first as the quotient bits come out
	logic [W-1:0] ir1_q, it0_q, it1_q, irem_q, isrc_q, iacc_q;
	logic         ibusy_q, idone_q, ifail_q;
	logic [CW:0]  icnt_q;
	logic [W:0]   itrial, idiff;
	logic         iqbit, ilast;
	logic [W-1:0] irem_nx, iacc2, iacc3, it2;

	assign itrial  = {irem_q, isrc_q[W-1]};
	assign iqbit   = (itrial >= {1'b0, ir1_q});
	assign idiff   = itrial - {1'b0, ir1_q};
	assign irem_nx = iqbit ? idiff[W-1:0] : itrial[W-1:0];
	assign iacc2   = addm(iacc_q, iacc_q, m);
	assign iacc3   = iqbit ? addm(iacc2, it1_q, m) : iacc2;
	assign it2     = subm(it0_q, iacc3, m);
	assign ilast   = (icnt_q == (CW+1)'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibusy_q <= 1'b0;
			idone_q <= 1'b0;
			ifail_q <= 1'b0;
			icnt_q  <= '0;
		end else begin
			idone_q <= ibusy_q && ilast && (irem_nx == '0);
			if (cmd.op == OP_INV && !ibusy_q) begin
				ibusy_q <= 1'b1;
				ir1_q   <= den_q;
				isrc_q  <= m;
				irem_q  <= '0;
				it0_q   <= '0;
				it1_q   <= W'(1);
				iacc_q  <= '0;
				icnt_q  <= '0;
			end else if (ibusy_q) begin
				if (ilast) begin
					icnt_q <= '0;
					if (irem_nx == '0) begin
						// remainder zero: gcd is in r1, inverse in t1
						ibusy_q <= 1'b0;
						ifail_q <= (ir1_q != W'(1));
						inv_q   <= it1_q;
					end else begin
						ir1_q  <= irem_nx;
						isrc_q <= ir1_q;
						irem_q <= '0;
						it0_q  <= it1_q;
						it1_q  <= it2;
						iacc_q <= '0;
					end
				end else begin
					icnt_q <= icnt_q + (CW+1)'(1);
					isrc_q <= {isrc_q[W-2:0], 1'b0};
					irem_q <= irem_nx;
					iacc_q <= iacc3;
				end
			end
		end
	end

	// numerator / denominator and result assembly
	logic dbl;
	assign dbl = (x1_q == x2_q) && (y1_q == y2_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DEN: begin
				if (dbl) begin
					num_q <= addm(addm(addm(prod_q, prod_q, m), prod_q, m), a_q, m);
					den_q <= addm(y1_q, y1_q, m);
				end else begin
					num_q <= subm(y2_q, y1_q, m);
					den_q <= subm(x2_q, x1_q, m);
				end
			end
			OP_SLOPE: s_q <= prod_q;
			OP_X3: begin
				x3_q <= subm(subm(prod_q, x1_q, m), x2_q, m);
				rx_q <= subm(subm(prod_q, x1_q, m), x2_q, m);
			end
			OP_Y3: begin
				ry_q   <= subm(prod_q, y1_q, m);
				rinf_q <= 1'b0;
			end
			OP_INF: begin
				rx_q   <= '0;
				ry_q   <= '0;
				rinf_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign sts.red_done  = red_done_q;
	assign sts.mul_done  = mdone_q;
	assign sts.inv_done  = idone_q;
	assign sts.inv_fail  = ifail_q;
	assign sts.den_zero  = (den_q == '0);
	assign sts.mod_small = (m < W'(2));
	assign res_x   = rx_q;
	assign res_y   = ry_q;
	assign res_inf = rinf_q;

endmodule

>>> rtl/ecpa_ctrl.sv
// ----------------------------------------------------------------------------
// ecpa_ctrl
// Sequencer for one point addition and the output transaction register.
// ----------------------------------------------------------------------------
`include "ec_affine_point_add_double_defines.svh"
module ecpa_ctrl import ecpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ecpa_cmd_t cmd,
	input  ecpa_sts_t sts
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RED   = 4'd1;
	localparam logic [3:0] S_SQ    = 4'd2;
	localparam logic [3:0] S_SQW   = 4'd3;
	localparam logic [3:0] S_DEN   = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_INVW  = 4'd6;
	localparam logic [3:0] S_SLW   = 4'd7;
	localparam logic [3:0] S_SSW   = 4'd8;
	localparam logic [3:0] S_YW    = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;
	localparam logic [3:0] S_INF   = 4'd11;
	localparam logic [3:0] S_INVS  = 4'd12;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.msel = MSEL_X1X1;
		case (state_q)
			S_IDLE: if (in_valid) begin
				if (sts.mod_small) begin
					state_d = S_INF;
				end else begin
					cmd.op  = OP_LOAD;
					state_d = S_RED;
				end
			end
			S_RED: if (sts.red_done) begin
				cmd.op  = OP_MUL;
				state_d = S_SQW;
			end
			S_SQW: if (sts.mul_done) state_d = S_DEN;
			S_DEN: begin
				cmd.op  = OP_DEN;
				state_d = S_CHK;
			end
			S_CHK: state_d = sts.den_zero ? S_INF : S_INVS;
			S_INVS: begin
				cmd.op  = OP_INV;
				state_d = S_INVW;
			end
			S_INVW: if (sts.inv_done) begin
				if (sts.inv_fail) begin
					state_d = S_INF;
				end else begin
					cmd.op   = OP_MUL;
					cmd.msel = MSEL_NINV;
					state_d  = S_SLW;
				end
			end
			S_SLW: if (sts.mul_done) begin
				cmd.op  = OP_SLOPE;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_SS;
				state_d  = S_SSW;
			end
			S_SSW: if (sts.mul_done) begin
				cmd.op  = OP_X3;
				state_d = S_YW;
			end
			S_YW: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_SDX;
				state_d  = S_OUT;
			end
			S_OUT: if (sts.mul_done) begin
				cmd.op  = OP_Y3;
				state_d = S_IDLE;
			end
			S_INF: begin
				cmd.op  = OP_INF;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// hold the sequencer while a finished result is still pending
		if (out_valid_q && !out_ready && (state_q == S_IDLE)) state_d = S_IDLE;
	end

	logic finish;
	assign finish = (cmd.op == OP_Y3) || (cmd.op == OP_INF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`EC_ASSERT_IMP(a_no_accept_busy, (state_q != S_IDLE), !in_ready, "ready while busy")
	`EC_ASSERT_NXT(a_finish_valid, finish, out_valid, "result not presented")
	`EC_ASSERT_IMP(a_inv_after_den, (state_q == S_INVW), !sts.den_zero, "inverse of zero")

endmodule

>>> rtl/ec_affine_point_add_double.sv
// Affine elliptic-curve point adder/doubler over GF(p), one transaction at a time.
// Flow: serial reduction of five values, four serial multiplies and a Euclid inverse.
// Early exits to infinity: modulus below two, zero denominator or no inverse.
// Next input accepted in the cycle after the result is taken.
// Reset: asynchronous active low, modulus 7 and coefficient 3, no result pending.
// ----------------------------------------------------------------------------
// ec_affine_point_add_double
// Top level: APB register file, input/output handshake, controller, datapath.
// ----------------------------------------------------------------------------
module ec_affine_point_add_double import ecpa_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] first_x,
	input  logic [COORD_BITS-1:0] first_y,
	input  logic [COORD_BITS-1:0] second_x,
	input  logic [COORD_BITS-1:0] second_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] sum_x,
	output logic [COORD_BITS-1:0] sum_y,
	output logic                  at_infinity
);
	localparam int W = COORD_BITS;
	localparam logic [2:0] ADDR_MOD = 3'd0;
	localparam logic [2:0] ADDR_A   = 3'd4;

	logic [W-1:0] mod_q, a_q;
	ecpa_cmd_t    cmd;
	ecpa_sts_t    sts;
	logic         ctrl_in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= W'(7);
			a_q   <= W'(3);
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_MOD: mod_q <= W'(64'(pwdata));
				ADDR_A:   a_q   <= W'(64'(pwdata));
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_MOD: prdata = 32'(64'(mod_q));
			ADDR_A:   prdata = 32'(64'(a_q));
			default:  prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// no new transaction while a result waits
	assign in_ready = ctrl_in_ready && !out_valid;

	ecpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid && !out_valid), .in_ready(ctrl_in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	ecpa_datapath #(.W(W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.prime_modulus(mod_q), .curve_coeff_a(a_q),
		.first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y),
		.res_x(sum_x), .res_y(sum_y), .res_inf(at_infinity)
	);

endmodule
